@@ rtl/hex_face_identifier_macros.svh @@
// Assertion macros for the hex face identifier checker.
// No dependencies.
`ifndef HEX_FACE_IDENTIFIER_MACROS_SVH
`define HEX_FACE_IDENTIFIER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HFI_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("hfi check failed");
// Next-cycle implication checked outside reset.
`define HFI_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("hfi check failed");
`endif

@@ rtl/hfi_pkg.sv @@
// Package for the hex face identifier: widths, face corner table, state codes.
// No dependencies.
`default_nettype none
package hfi_pkg;
    localparam int CW = 32;
    localparam int SW = 36;
    localparam int DW = 41;           // |n*C - 4*S| magnitude bits
    localparam int QW = 96;           // squared distance sum
    localparam int NFACE = 6;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic            kind;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [CW-1:0]   z;
        logic            last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_AXIS, ST_SQ, ST_CMP, ST_TOL, ST_TSQ, ST_OUT
    } state_t;

    function automatic logic [2:0] corner_of(input logic [2:0] f, input logic [1:0] k);
        logic [11:0] row;
        begin
            case (f)
                3'd0: row = {3'd3, 3'd2, 3'd1, 3'd0};
                3'd1: row = {3'd7, 3'd6, 3'd5, 3'd4};
                3'd2: row = {3'd4, 3'd5, 3'd1, 3'd0};
                3'd3: row = {3'd7, 3'd6, 3'd2, 3'd3};
                3'd4: row = {3'd4, 3'd7, 3'd3, 3'd0};
                3'd5: row = {3'd5, 3'd6, 3'd2, 3'd1};
                default: row = '0;
            endcase
            corner_of = row[k*3 +: 3];
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/hfi_queue.sv @@
// Two-entry queue between front and back of the hex face identifier.
// Depends on hfi_pkg.
`default_nettype none
module hfi_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  hfi_pkg::item_t      in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hfi_pkg::item_t      out_item
);
    import hfi_pkg::*;
    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Store pushed item
    always_ff @(posedge clk) begin
        if (push) mem_reg[wp_reg] <= in_item;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/hfi_back.sv @@
// Back end: node accumulation, corner store, bounding box, face search.
// Depends on hfi_pkg.
`default_nettype none
module hfi_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [4:0]   npe,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  hfi_pkg::item_t    in_item,
    output logic              res_valid,
    input  wire logic         res_ready,
    output logic [2:0]        res_face,
    output logic              res_far
);
    import hfi_pkg::*;

    logic signed [CW-1:0] corner_reg [24];
    logic signed [CW-1:0] bmin_reg [3];
    logic signed [CW-1:0] bmax_reg [3];
    logic signed [SW-1:0] fsum_reg [3];
    logic [4:0]  ncnt_reg;
    logic [3:0]  fcnt_reg;
    logic        loading_reg;

    state_t state_reg, state_next;
    logic [2:0]  face_reg;
    logic [1:0]  axis_reg;
    logic [DW-1:0] mag_reg;
    logic [1:0]  sq_step_reg;
    logic [QW-1:0] dist_reg, best_reg;
    logic [QW+19:0] scl_reg;
    logic [2:0]  bface_reg;
    logic        far_reg;
    logic        rv_reg;
    logic [2:0]  rface_reg;

    logic accept;
    logic signed [CW-1:0] p [3];
    logic [3:0] expect_n;

    assign p[0] = in_item.x;
    assign p[1] = in_item.y;
    assign p[2] = in_item.z;
    assign expect_n = (npe == 5'd8) ? 4'd4 : 4'd9;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;
    assign res_valid = rv_reg;
    assign res_face = rface_reg;
    assign res_far = far_reg;

    // Corner sum and distance term for current face and axis
    logic signed [CW+1:0] s4;
    logic signed [DW:0] dterm;
    logic [DW-1:0] dmag;
    always_comb
    begin
        s4 = '0;
        for (int k = 0; k < 4; k++)
            s4 = s4 + (CW+2)'(corner_reg[{corner_of(face_reg, 2'(k)), 2'b00}
                 - {2'b00, corner_of(face_reg, 2'(k))} + 5'(axis_reg)]);
        dterm = (DW+1)'($signed({1'b0, fcnt_reg}) * s4)
              - (DW+1)'($signed({fsum_reg[axis_reg], 2'b00}));
        dmag = dterm[DW] ? DW'(-dterm) : dterm[DW-1:0];
    end

    // Tolerance base: 4 * n * largest extent
    logic signed [CW:0] ext [3];
    logic [CW:0] lc;
    logic [CW+6:0] t;
    always_comb
    begin
        lc = '0;
        for (int c = 0; c < 3; c++)
        begin
            ext[c] = (CW+1)'(bmax_reg[c]) - (CW+1)'(bmin_reg[c]);
            if (!ext[c][CW] && ext[c][CW-1:0] > lc[CW-1:0]) lc = {1'b0, ext[c][CW-1:0]};
        end
        t = (CW+7)'({fcnt_reg, 2'b00}) * (CW+7)'(lc);
    end

    // Shared squarer: one 21x21-bit partial product per step (lo*lo, lo*hi, hi*hi)
    logic [20:0] sq_a, sq_b;
    logic [41:0] sq_prod;
    logic [QW-1:0] sq_term;
    always_comb
    begin
        case (sq_step_reg)
            2'd0:
            begin
                sq_a = mag_reg[20:0];
                sq_b = mag_reg[20:0];
            end
            2'd1:
            begin
                sq_a = mag_reg[20:0];
                sq_b = {1'b0, mag_reg[40:21]};
            end
            default:
            begin
                sq_a = {1'b0, mag_reg[40:21]};
                sq_b = {1'b0, mag_reg[40:21]};
            end
        endcase
        sq_prod = sq_a * sq_b;
        case (sq_step_reg)
            2'd0:    sq_term = QW'(sq_prod);
            2'd1:    sq_term = QW'(sq_prod) << 22;
            default: sq_term = QW'(sq_prod) << 42;
        endcase
    end

    // Sequence the face search
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && in_item.kind && in_item.last) state_next = ST_AXIS;
            ST_AXIS: state_next = ST_SQ;
            ST_SQ:
                if (sq_step_reg == 2'd2)
                    state_next = (axis_reg == 2'd2) ? ST_CMP : ST_AXIS;
            ST_CMP:  state_next = (face_reg == 3'(NFACE-1)) ? ST_TOL : ST_AXIS;
            ST_TOL:  state_next = ST_TSQ;
            ST_TSQ:  if (sq_step_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:  if (!rv_reg || res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    // Data path registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            ncnt_reg <= '0; fcnt_reg <= '0; loading_reg <= 1'b0;
            rv_reg <= 1'b0; far_reg <= 1'b0; rface_reg <= '0;
            face_reg <= '0; axis_reg <= '0; bface_reg <= '0;
            mag_reg <= '0; sq_step_reg <= '0; dist_reg <= '0;
            best_reg <= '0; scl_reg <= '0;
            for (int i = 0; i < 24; i++) corner_reg[i] <= '0;
            for (int c = 0; c < 3; c++)
            begin
                bmin_reg[c] <= CMAX; bmax_reg[c] <= CMIN; fsum_reg[c] <= '0;
            end
        end
        else
        begin
            // Raise the result when it is loaded, drop it on its transfer
            if (state_reg == ST_OUT && (!rv_reg || res_ready)) rv_reg <= 1'b1;
            else if (rv_reg && res_ready) rv_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !in_item.kind)
                    begin
                        loading_reg <= 1'b1;
                        if (!loading_reg)
                        begin
                            // Start a new element from a cleared box
                            if (npe != 5'd0)
                            begin
                                ncnt_reg <= 5'd1;
                                corner_reg[0] <= p[0]; corner_reg[1] <= p[1];
                                corner_reg[2] <= p[2];
                                for (int c = 0; c < 3; c++)
                                begin
                                    bmin_reg[c] <= p[c]; bmax_reg[c] <= p[c];
                                end
                            end
                            else
                            begin
                                ncnt_reg <= 5'd0;
                                for (int c = 0; c < 3; c++)
                                begin
                                    bmin_reg[c] <= CMAX; bmax_reg[c] <= CMIN;
                                end
                            end
                        end
                        else if (ncnt_reg < npe)
                        begin
                            ncnt_reg <= ncnt_reg + 5'd1;
                            if (ncnt_reg < 5'd8)
                                for (int c = 0; c < 3; c++)
                                    corner_reg[5'(ncnt_reg*3 + c)] <= p[c];
                            for (int c = 0; c < 3; c++)
                            begin
                                if (p[c] < bmin_reg[c]) bmin_reg[c] <= p[c];
                                if (p[c] > bmax_reg[c]) bmax_reg[c] <= p[c];
                            end
                        end
                    end
                    else if (accept)
                    begin
                        loading_reg <= 1'b0;
                        if (fcnt_reg < expect_n)
                        begin
                            fcnt_reg <= fcnt_reg + 4'd1;
                            for (int c = 0; c < 3; c++)
                                fsum_reg[c] <= fsum_reg[c] + SW'(p[c]);
                        end
                        face_reg <= '0; axis_reg <= '0; dist_reg <= '0;
                    end
                end
                ST_AXIS:
                begin
                    mag_reg <= dmag;
                    sq_step_reg <= 2'd0;
                end
                ST_SQ:
                begin
                    dist_reg <= dist_reg + sq_term;
                    if (sq_step_reg == 2'd2)
                    begin
                        sq_step_reg <= 2'd0;
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                    else
                        sq_step_reg <= sq_step_reg + 2'd1;
                end
                ST_CMP:
                begin
                    if (face_reg == 3'd0 || dist_reg < best_reg)
                    begin
                        best_reg <= dist_reg; bface_reg <= face_reg;
                    end
                    face_reg <= face_reg + 3'd1;
                    dist_reg <= '0;
                end
                ST_TOL:
                begin
                    // Load the tolerance base into the squarer, start scaling
                    mag_reg <= {2'b00, t};
                    dist_reg <= '0;
                    scl_reg <= (QW+20)'(best_reg);
                    sq_step_reg <= 2'd0;
                end
                ST_TSQ:
                begin
                    // Square the tolerance base; scale the best distance by 1000 twice
                    dist_reg <= dist_reg + sq_term;
                    if (sq_step_reg != 2'd2)
                        scl_reg <= (scl_reg << 10) - (scl_reg << 4) - (scl_reg << 3);
                    sq_step_reg <= (sq_step_reg == 2'd2) ? 2'd0 : sq_step_reg + 2'd1;
                end
                ST_OUT:
                begin
                    if (!rv_reg || res_ready)
                    begin
                        far_reg <= (ncnt_reg == 5'd0) || (scl_reg > (QW+20)'(dist_reg));
                        rface_reg <= bface_reg;
                        fcnt_reg <= '0;
                        for (int c = 0; c < 3; c++) fsum_reg[c] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/hex_face_identifier.sv @@
// Hex face identifier top level: config register, front queue, back end.
// Throughput: one node per cycle while the back end is idle; a decision holds
// the back end busy through its search and its result hand-off (six faces of
// three axes, each through one shared squarer in three steps).
// Reset: asynchronous active low; clears counts, box and sums; register to 8.
`default_nettype none
module hex_face_identifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [31:0] coord_x,
    input  wire logic [31:0] coord_y,
    input  wire logic [31:0] coord_z,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       face_code,
    output logic             too_far,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    import hfi_pkg::*;
    logic [4:0] npe_reg;
    item_t      in_item, q_item;
    logic       q_valid, q_ready;

    assign cfg_ready = 1'b1;
    assign in_item = '{kind: kind, x: coord_x, y: coord_y, z: coord_z, last: last};

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) npe_reg <= 5'd8;
        else if (cfg_valid) npe_reg <= cfg_data;
    end

    hfi_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    hfi_back u_back (
        .clk(clk), .rst_n(rst_n), .npe(npe_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .res_valid(out_valid), .res_ready(out_ready),
        .res_face(face_code), .res_far(too_far)
    );
endmodule
`default_nettype wire

@@ rtl/hfi_checker.sv @@
// Port-level checker for the hex face identifier, bound to the top level.
// Depends on hex_face_identifier_macros.svh.
`default_nettype none
`include "hex_face_identifier_macros.svh"
module hfi_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] face_code,
    input wire logic       cfg_ready
);
    `HFI_ASSERT_IMP(a_face_range, clk, rst_n, out_valid, face_code <= 3'd5)
    `HFI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(face_code))
    `HFI_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)
endmodule
bind hex_face_identifier hfi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .face_code(face_code), .cfg_ready(cfg_ready)
);
`default_nettype wire

@@ tb/hex_face_identifier_tb.sv @@
// Self-checking testbench for hex_face_identifier: element/face node streams,
// exact face prediction, random idling and stalls. Depends on rtl/hfi_pkg.sv
// and the hex_face_identifier RTL.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: predicts face decisions from accepted nodes and checks results
class face_scoreboard;
    localparam int NPE_RESET = 8;
    longint corner_xyz [24];
    longint box_lo [3];
    longint box_hi [3];
    longint sum_xyz [3];
    int     elem_nodes;
    int     face_cnt;
    bit     loading;
    int     npe;
    bit [2:0] face_q [$];
    bit       far_q [$];
    int     errors;
    int     decisions;
    int     far_count;

    function new();
        errors = 0;
        decisions = 0;
        far_count = 0;
        npe = NPE_RESET;
        foreach (corner_xyz[i]) corner_xyz[i] = 0;
        foreach (sum_xyz[i]) sum_xyz[i] = 0;
        elem_nodes = 0;
        face_cnt = 0;
        loading = 0;
        clear_box();
    endfunction

    function void clear_box();
        for (int c = 0; c < 3; c++)
        begin
            box_lo[c] = 64'sd2147483647;
            box_hi[c] = -64'sd2147483648;
        end
    endfunction

    function int corner_idx(int f, int k);
        int tbl [6][4];
        tbl = '{'{0, 1, 2, 3}, '{4, 5, 6, 7}, '{0, 1, 5, 4},
                '{3, 2, 6, 7}, '{0, 3, 7, 4}, '{1, 2, 6, 5}};
        return tbl[f][k];
    endfunction

    // Note one accepted node; push an expected decision on a last face node
    function void note_node(bit kind, bit [31:0] x, bit [31:0] y, bit [31:0] z,
                            bit last);
        longint p [3];
        int expect_n;
        bit [191:0] best, dsq, lhs, rhs;
        bit [63:0] mg;
        longint s4, d, lc, e;
        int best_face;
        bit far;
        p[0] = longint'(signed'(x));
        p[1] = longint'(signed'(y));
        p[2] = longint'(signed'(z));
        if (!kind)
        begin
            if (!loading)
            begin
                elem_nodes = 0;
                clear_box();
                loading = 1;
            end
            if (elem_nodes < npe)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (elem_nodes < 8) corner_xyz[elem_nodes*3 + c] = p[c];
                    if (p[c] < box_lo[c]) box_lo[c] = p[c];
                    if (p[c] > box_hi[c]) box_hi[c] = p[c];
                end
                elem_nodes++;
            end
            return;
        end
        loading = 0;
        expect_n = (npe == 8) ? 4 : 9;
        if (face_cnt < expect_n)
        begin
            for (int c = 0; c < 3; c++) sum_xyz[c] += p[c];
            face_cnt++;
        end
        if (!last) return;
        best = '0;
        best_face = 0;
        for (int f = 0; f < 6; f++)
        begin
            dsq = '0;
            for (int c = 0; c < 3; c++)
            begin
                s4 = 0;
                for (int k = 0; k < 4; k++) s4 += corner_xyz[corner_idx(f, k)*3 + c];
                d = longint'(face_cnt) * s4 - 4 * sum_xyz[c];
                mg = (d < 0) ? 64'(-d) : 64'(d);
                dsq += 192'(mg) * 192'(mg);
            end
            if (f == 0 || dsq < best)
            begin
                best = dsq;
                best_face = f;
            end
        end
        if (elem_nodes == 0)
            far = 1;
        else
        begin
            lc = 0;
            for (int c = 0; c < 3; c++)
            begin
                e = box_hi[c] - box_lo[c];
                if (e > lc) lc = e;
            end
            rhs = 192'(4 * face_cnt) * 192'(lc);
            rhs = rhs * rhs;
            lhs = best * 192'd1000000;
            far = lhs > rhs;
        end
        foreach (sum_xyz[i]) sum_xyz[i] = 0;
        face_cnt = 0;
        face_q.push_back(3'(best_face));
        far_q.push_back(far);
        decisions++;
        if (far) far_count++;
    endfunction

    function void check_result(bit [2:0] face, bit far);
        bit [2:0] ef;
        bit       ex;
        if (face_q.size() == 0)
        begin
            $error("unexpected result face_code=%0d too_far=%0d", face, far);
            errors++;
            return;
        end
        ef = face_q.pop_front();
        ex = far_q.pop_front();
        if (face != ef)
        begin
            $error("face_code expected %0d actual %0d", ef, face);
            errors++;
        end
        if (far != ex)
        begin
            $error("too_far expected %0d actual %0d", ex, far);
            errors++;
        end
    endfunction

    function int pending();
        return face_q.size();
    endfunction
endclass

module hex_face_identifier_tb;
    import hfi_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 60;
    localparam int LONG_STALL = 300;
    localparam int ELEMS_PER_PHASE = 2;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  face_code;
    logic        too_far;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    face_scoreboard faces;
    int  idle_cycles;
    int  sent_items;
    bit  hold_off;
    int  burst_left;

    hex_face_identifier dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .coord_x           (coord_x),
        .coord_y           (coord_y),
        .coord_z           (coord_z),
        .last              (last),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .face_code         (face_code),
        .too_far           (too_far),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver: stall pattern, with a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 9) < 7);
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            faces.check_result(face_code, too_far);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("hex_face_identifier regression: fail");
            $finish;
        end
    end

    // Send one node; gaps come from a burst/gap pattern
    task automatic send_node(bit k, bit [31:0] x, bit [31:0] y, bit [31:0] z, bit l);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        kind     <= k;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        last     <= l;
        do @(posedge clk); while (!in_ready);
        faces.note_node(k, x, y, z, l);
        sent_items++;
    endtask

    // Drop valid, then wait until every expected decision has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (faces.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_npe(bit [4:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        faces.npe = v;
    endtask

    function automatic bit [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return 32'(signed'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    // One element: corners near a cube (random in mode 0), then one or more faces
    task automatic send_element(int mode, bit [4:0] npe, int n_faces);
        int base, f, nn, extra;
        bit [31:0] cx [8], cy [8], cz [8];
        int tbl [6][4];
        tbl = '{'{0, 1, 2, 3}, '{4, 5, 6, 7}, '{0, 1, 5, 4},
                '{3, 2, 6, 7}, '{0, 3, 7, 4}, '{1, 2, 6, 5}};
        base = $urandom_range(1, 1000) << 12;
        nn = npe + (($urandom_range(0, 7) == 0) ? 2 : 0);
        for (int i = 0; i < nn; i++)
        begin
            if (i < 8 && mode != 0)
            begin
                cx[i] = base * ((i == 1 || i == 2 || i == 5 || i == 6) ? 1 : -1);
                cy[i] = base * ((i == 2 || i == 3 || i == 6 || i == 7) ? 1 : -1);
                cz[i] = base * ((i >= 4) ? 1 : -1);
                cx[i] += $urandom_range(0, 255);
            end
            else
            begin
                cx[i % 8] = rand_coord(0);
                cy[i % 8] = rand_coord(0);
                cz[i % 8] = rand_coord(0);
            end
            send_node(1'b0, cx[i % 8], cy[i % 8], cz[i % 8], 1'($urandom_range(0, 1)));
        end
        for (int j = 0; j < n_faces; j++)
        begin
            f = $urandom_range(0, 5);
            nn = (npe == 8) ? 4 : 9;
            extra = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 0;
            nn = nn + extra - (($urandom_range(0, 5) == 0) ? 1 : 0);
            for (int i = 0; i < nn; i++)
            begin
                if ($urandom_range(0, 3) == 0 || mode == 0)
                    send_node(1'b1, rand_coord(mode), rand_coord(mode),
                              rand_coord(mode), i == nn - 1);
                else
                    send_node(1'b1, cx[tbl[f][i % 4]] + $urandom_range(0, 3),
                              cy[tbl[f][i % 4]], cz[tbl[f][i % 4]], i == nn - 1);
            end
        end
    endtask

    // Long receiver hold-off counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (sent_items > 150);
        hold_off = 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        bit [4:0] npe_set [5];
        faces = new();
        npe_set = '{5'd27, 5'd8, 5'd9, 5'd31, 5'd8};
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        last = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 5'd8;
        sent_items = 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: face before any element, extremes, near-corner faces
        send_node(1'b1, 32'h7fffffff, 32'h80000000, 32'h0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_node(1'b0, (i & 1) ? 32'h7fffffff : 32'h80000000,
                      (i & 2) ? 32'hffffffff : 32'h0,
                      (i & 4) ? 32'h00010000 : 32'h0, i == 3);
        send_node(1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
        send_node(1'b1, 32'h0, 32'h0, 32'h0, 1'b1);
        // all-zero element gives tied faces and zero extent
        for (int i = 0; i < 8; i++) send_node(1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
        for (int i = 0; i < 4; i++) send_node(1'b1, 32'h0, 32'h0, 32'h0, i == 3);
        for (int f = 0; f < 6; f++) send_element(1, 5'd8, 1);

        // Sender pause until everything is back
        wait_drained();

        // Random phases over register settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            write_npe(npe_set[ph]);
            for (int e = 0; e < ELEMS_PER_PHASE; e++)
                send_element($urandom_range(0, 2), npe_set[ph], $urandom_range(1, 3));
        end

        wait_drained();
        $display("covered %0d nodes, %0d face decisions (%0d too far), 5 register settings",
                 sent_items, faces.decisions, faces.far_count);
        if (faces.errors == 0 && faces.pending() == 0)
            $display("hex_face_identifier regression: pass");
        else
            $display("hex_face_identifier regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
